FILE: hw/rtl/msr_pkg.sv
// Shared types and constants for the multi-channel servo slew ramp.
`timescale 1ns / 1ps

package msr_pkg;

	localparam int MAX_CH       = 4;
	localparam int NUM_CHANNELS = 4;
	localparam int NUM_REGS     = 2 * MAX_CH;
	localparam int CFG_IDX_W    = 4;
	localparam int ANGLE_W      = 8;
	localparam int POS_W        = 8;
	localparam int PHYS_W       = ANGLE_W + 2;

	localparam logic signed [PHYS_W-1:0] LOGIC_MID = PHYS_W'(90);
	localparam logic signed [PHYS_W-1:0] PHYS_MAX  = PHYS_W'(180);

	localparam logic signed [ANGLE_W-1:0] RESET_MIN [MAX_CH] =
		'{-8'sd90, -8'sd90, 8'sd0, -8'sd20};
	localparam logic signed [ANGLE_W-1:0] RESET_MAX [MAX_CH] =
		'{8'sd90, 8'sd0, 8'sd90, 8'sd40};

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [1:0] {
		OP_SET_ALL = 2'd0,
		OP_SET_ONE = 2'd1,
		OP_TICK    = 2'd2,
		OP_RSVD    = 2'd3
	} op_t;

	typedef struct packed {
		pos_t pos;
		logic moved;
		logic settled;
	} lane_res_t;

endpackage

FILE: hw/rtl/msr_if.sv
// Handshake interfaces for the command, result and configuration channels.
`timescale 1ns / 1ps

interface msr_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        operation;
	logic [1:0]                        channel;
	logic signed [msr_pkg::ANGLE_W-1:0] single_angle;
	logic signed [msr_pkg::ANGLE_W-1:0] angle_0;
	logic signed [msr_pkg::ANGLE_W-1:0] angle_1;
	logic signed [msr_pkg::ANGLE_W-1:0] angle_2;
	logic signed [msr_pkg::ANGLE_W-1:0] angle_3;

	modport source (output valid, operation, channel, single_angle,
		angle_0, angle_1, angle_2, angle_3, input ready);
	modport sink (input valid, operation, channel, single_angle,
		angle_0, angle_1, angle_2, angle_3, output ready);
endinterface

interface msr_res_if;
	logic                      valid;
	logic                      ready;
	logic [msr_pkg::POS_W-1:0] pos_0;
	logic [msr_pkg::POS_W-1:0] pos_1;
	logic [msr_pkg::POS_W-1:0] pos_2;
	logic [msr_pkg::POS_W-1:0] pos_3;
	logic                      moved;
	logic                      settled;

	modport source (output valid, pos_0, pos_1, pos_2, pos_3, moved, settled,
		input ready);
	modport sink (input valid, pos_0, pos_1, pos_2, pos_3, moved, settled,
		output ready);
endinterface

interface msr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [msr_pkg::CFG_IDX_W-1:0] idx;
	logic [msr_pkg::ANGLE_W-1:0]   data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

FILE: hw/rtl/multi_servo_slew_ramp.sv
// Top level of the four-channel servo slew ramp with limit registers.
`timescale 1ns / 1ps

// The cmd channel carries one item per request: set all targets, set one
// target or tick the ramp, with a reserved code that changes nothing. Every
// accepted item gives exactly one item on the res channel with the physical
// angle of each channel and the moved and settled flags after the update.
// The cfg channel writes the per-channel minimum and maximum limits; it is
// always ready and writes to indexes beyond the list are dropped.
// Each channel is a lane that updates its state in the cycle the item is
// accepted, and the result is registered in the output register, or in the
// skid stage when the receiver stalls. While the skid stage is empty the
// rate is one item per cycle; each lane compares and steps combinationally.
// When the receiver stalls, one further result is held in a skid stage and
// cmd.ready drops until that stage drains.
// Reset clears all angles to zero, loads the default limits and empties the
// output register and skid stage.

module multi_servo_slew_ramp (
	input  logic      clk,
	input  logic      arst_n,
	msr_cmd_if.sink   cmd,
	msr_res_if.source res,
	msr_cfg_if.sink   cfg
);

	msr_pkg::lane_res_t lane_res [msr_pkg::NUM_CHANNELS];
	msr_pkg::angle_t    req_angle [msr_pkg::MAX_CH];
	logic               take_ok;
	logic               accept;
	logic               cfg_hit;

	assign cmd.ready = take_ok;
	assign cfg.ready = 1'b1;
	assign accept    = cmd.valid && take_ok;
	assign cfg_hit   = cfg.valid && (cfg.idx < msr_pkg::CFG_IDX_W'(msr_pkg::NUM_REGS));

	assign req_angle[0] = cmd.angle_0;
	assign req_angle[1] = cmd.angle_1;
	assign req_angle[2] = cmd.angle_2;
	assign req_angle[3] = cmd.angle_3;

	for (genvar c = 0; c < msr_pkg::NUM_CHANNELS; c++) begin : g_lane
		msr_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.rst_min      (msr_pkg::RESET_MIN[c]),
			.rst_max      (msr_pkg::RESET_MAX[c]),
			.min_we       (cfg_hit && (cfg.idx[2:1] == 2'(c)) && !cfg.idx[0]),
			.max_we       (cfg_hit && (cfg.idx[2:1] == 2'(c)) && cfg.idx[0]),
			.cfg_data     (cfg.data),
			.upd          (accept),
			.op           (msr_pkg::op_t'(cmd.operation)),
			.sel          (cmd.channel == 2'(c)),
			.single_angle (cmd.single_angle),
			.lane_angle   (req_angle[c]),
			.res          (lane_res[c])
		);
	end

	msr_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.lane_res (lane_res),
		.take_ok  (take_ok),
		.res      (res)
	);

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> res.valid)
		else $error("accepted item did not produce a result");

	a_stall_means_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> res.valid)
		else $error("input stalled with no result pending");

	a_stall_holds_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready && !res.ready |=> !cmd.ready)
		else $error("skid stage drained while output was stalled");

endmodule

FILE: hw/rtl/msr_lane.sv
// One servo channel: limits, target and current angle with one-degree ramp.
`timescale 1ns / 1ps

module msr_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  msr_pkg::angle_t    rst_min,
	input  msr_pkg::angle_t    rst_max,
	input  logic               min_we,
	input  logic               max_we,
	input  msr_pkg::angle_t    cfg_data,
	input  logic               upd,
	input  msr_pkg::op_t       op,
	input  logic               sel,
	input  msr_pkg::angle_t    single_angle,
	input  msr_pkg::angle_t    lane_angle,
	output msr_pkg::lane_res_t res
);

	msr_pkg::angle_t min_q, max_q, cur_q, tgt_q;
	msr_pkg::angle_t cur_n, tgt_n;
	logic            step;
	logic signed [msr_pkg::PHYS_W-1:0] phys;

	function automatic msr_pkg::angle_t clamp(msr_pkg::angle_t req,
		msr_pkg::angle_t lo, msr_pkg::angle_t hi);
		msr_pkg::angle_t r;
		if (req < lo) begin
			r = lo;
		end else if (req > hi) begin
			r = hi;
		end else begin
			r = req;
		end
		return r;
	endfunction

	always_comb begin
		tgt_n = tgt_q;
		cur_n = cur_q;
		step  = 1'b0;
		if (upd) begin
			unique case (op)
				msr_pkg::OP_SET_ALL: begin
					tgt_n = clamp(lane_angle, min_q, max_q);
				end
				msr_pkg::OP_SET_ONE: begin
					if (sel) begin
						tgt_n = clamp(single_angle, min_q, max_q);
					end
				end
				msr_pkg::OP_TICK: begin
					if (cur_q < tgt_q) begin
						cur_n = cur_q + 8'sd1;
						step  = 1'b1;
					end else if (cur_q > tgt_q) begin
						cur_n = cur_q - 8'sd1;
						step  = 1'b1;
					end
				end
				msr_pkg::OP_RSVD: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		phys        = msr_pkg::LOGIC_MID - msr_pkg::PHYS_W'(cur_n);
		res.moved   = step;
		res.settled = (cur_n == tgt_n);
		if (phys < 0) begin
			res.pos = '0;
		end else if (phys > msr_pkg::PHYS_MAX) begin
			res.pos = msr_pkg::POS_W'(msr_pkg::PHYS_MAX);
		end else begin
			res.pos = phys[msr_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= rst_min;
			max_q <= rst_max;
			cur_q <= '0;
			tgt_q <= '0;
		end else begin
			if (min_we) begin
				min_q <= cfg_data;
			end
			if (max_we) begin
				max_q <= cfg_data;
			end
			if (upd) begin
				cur_q <= cur_n;
				tgt_q <= tgt_n;
			end
		end
	end

endmodule

FILE: hw/rtl/msr_merge.sv
// Combines the lane results and holds them in an output register with a skid stage.
`timescale 1ns / 1ps

module msr_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  msr_pkg::lane_res_t lane_res [msr_pkg::NUM_CHANNELS],
	output logic               take_ok,
	msr_res_if.source          res
);

	typedef struct packed {
		msr_pkg::pos_t [msr_pkg::MAX_CH-1:0] pos;
		logic                                moved;
		logic                                settled;
	} result_t;

	result_t new_res, out_q, skid_q;
	logic    out_v_q, skid_v_q;

	always_comb begin
		new_res.pos     = '0;
		new_res.moved   = 1'b0;
		new_res.settled = 1'b1;
		for (int i = 0; i < msr_pkg::NUM_CHANNELS; i++) begin
			new_res.pos[i]  = lane_res[i].pos;
			new_res.moved   = new_res.moved | lane_res[i].moved;
			new_res.settled = new_res.settled & lane_res[i].settled;
		end
	end

	assign take_ok     = !skid_v_q;
	assign res.valid   = out_v_q;
	assign res.pos_0   = out_q.pos[0];
	assign res.pos_1   = out_q.pos[1];
	assign res.pos_2   = out_q.pos[2];
	assign res.pos_3   = out_q.pos[3];
	assign res.moved   = out_q.moved;
	assign res.settled = out_q.settled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || res.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || res.ready) begin
			out_q <= skid_v_q ? skid_q : new_res;
		end else if (push) begin
			skid_q <= new_res;
		end
	end

endmodule

FILE: verif/servo_ramp_checker.sv
// Checker that predicts every servo ramp result and compares it with the block's output.
`timescale 1ns / 1ps

module servo_ramp_checker
	import msr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	msr_cmd_if   cmd,
	msr_res_if   res,
	msr_cfg_if   cfg,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		pos_t [MAX_CH-1:0] pos;
		logic              moved;
		logic              settled;
	} ramp_res_t;

	angle_t    cur_ang [MAX_CH];
	angle_t    tgt_ang [MAX_CH];
	angle_t    lim_lo [MAX_CH];
	angle_t    lim_hi [MAX_CH];
	ramp_res_t pos_q [$];
	int        fail_count = 0;
	int        waiting = 0;

	assign errors  = fail_count;
	assign pending = waiting;

	function automatic angle_t clamp_angle(int unsigned ch, angle_t req);
		if (req < lim_lo[ch])
			return lim_lo[ch];
		if (req > lim_hi[ch])
			return lim_hi[ch];
		return req;
	endfunction

	function automatic pos_t to_phys(angle_t a);
		int p;
		p = int'(LOGIC_MID) - int'(a);
		if (p < 0)
			p = 0;
		if (p > int'(PHYS_MAX))
			p = int'(PHYS_MAX);
		return pos_t'(p);
	endfunction

	function automatic ramp_res_t step_ramp(op_t op, logic [1:0] ch, angle_t one,
			angle_t [MAX_CH-1:0] req);
		ramp_res_t r;
		r = '0;
		r.settled = 1'b1;
		case (op)
			OP_SET_ALL: begin
				for (int i = 0; i < NUM_CHANNELS; i++)
					tgt_ang[i] = clamp_angle(i, req[i]);
			end
			OP_SET_ONE: begin
				if (ch < NUM_CHANNELS)
					tgt_ang[ch] = clamp_angle(ch, one);
			end
			OP_TICK: begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (cur_ang[i] < tgt_ang[i]) begin
						cur_ang[i] = cur_ang[i] + angle_t'(1);
						r.moved = 1'b1;
					end else if (cur_ang[i] > tgt_ang[i]) begin
						cur_ang[i] = cur_ang[i] - angle_t'(1);
						r.moved = 1'b1;
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			r.pos[i] = to_phys(cur_ang[i]);
			if (cur_ang[i] != tgt_ang[i])
				r.settled = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		ramp_res_t           seen;
		ramp_res_t           want;
		angle_t [MAX_CH-1:0] req;
		if (!arst_n) begin
			for (int i = 0; i < MAX_CH; i++) begin
				lim_lo[i]  = RESET_MIN[i];
				lim_hi[i]  = RESET_MAX[i];
				cur_ang[i] = '0;
				tgt_ang[i] = '0;
			end
			pos_q.delete();
			waiting <= 0;
		end else begin
			if (res.valid && res.ready) begin
				seen.pos[0]  = res.pos_0;
				seen.pos[1]  = res.pos_1;
				seen.pos[2]  = res.pos_2;
				seen.pos[3]  = res.pos_3;
				seen.moved   = res.moved;
				seen.settled = res.settled;
				if (pos_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with no item waiting, expected none, got %h",
						$time, seen);
				end else begin
					want = pos_q.pop_front();
					for (int i = 0; i < MAX_CH; i++) begin
						if (seen.pos[i] !== want.pos[i]) begin
							fail_count++;
							$display("%0t: pos_%0d expected %0d, got %0d", $time, i,
								want.pos[i], seen.pos[i]);
						end
					end
					if (seen.moved !== want.moved) begin
						fail_count++;
						$display("%0t: moved expected %b, got %b", $time, want.moved,
							seen.moved);
					end
					if (seen.settled !== want.settled) begin
						fail_count++;
						$display("%0t: settled expected %b, got %b", $time, want.settled,
							seen.settled);
					end
				end
			end
			if (cfg.valid && cfg.ready && cfg.idx < NUM_REGS) begin
				if (cfg.idx[0])
					lim_hi[cfg.idx >> 1] = angle_t'(cfg.data);
				else
					lim_lo[cfg.idx >> 1] = angle_t'(cfg.data);
			end
			if (cmd.valid && cmd.ready) begin
				req[0] = cmd.angle_0;
				req[1] = cmd.angle_1;
				req[2] = cmd.angle_2;
				req[3] = cmd.angle_3;
				pos_q.push_back(step_ramp(op_t'(cmd.operation), cmd.channel,
					cmd.single_angle, req));
			end
			waiting <= pos_q.size();
		end
	end

endmodule

FILE: verif/testbench.sv
// Top of the servo slew ramp testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
	import msr_pkg::*;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_CH0, REG_MAX_CH0, REG_MIN_CH1, REG_MAX_CH1,
		REG_MIN_CH2, REG_MAX_CH2, REG_MIN_CH3, REG_MAX_CH3
	} reg_idx_t;

	typedef struct packed {
		op_t                 op;
		logic [1:0]          ch;
		angle_t              one;
		angle_t [MAX_CH-1:0] ang;
	} servo_cmd_t;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_total;
	int   in_flight;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_off_len = 0;

	msr_cmd_if cmd ();
	msr_res_if res ();
	msr_cfg_if cfg ();

	multi_servo_slew_ramp u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.cfg    (cfg)
	);

	servo_ramp_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.cfg     (cfg),
		.errors  (fail_total),
		.pending (in_flight)
	);

	always #2 clk = ~clk;

	function automatic servo_cmd_t make_cmd(op_t op, logic [1:0] ch, angle_t one,
			angle_t a0, angle_t a1, angle_t a2, angle_t a3);
		servo_cmd_t c;
		c.op     = op;
		c.ch     = ch;
		c.one    = one;
		c.ang[0] = a0;
		c.ang[1] = a1;
		c.ang[2] = a2;
		c.ang[3] = a3;
		return c;
	endfunction

	function automatic angle_t rand_angle();
		if ($urandom_range(0, 2) == 0)
			return angle_t'($urandom);
		return angle_t'(int'($urandom_range(0, 40)) - 20);
	endfunction

	function automatic servo_cmd_t rand_cmd();
		servo_cmd_t  c;
		int unsigned pick;
		pick  = $urandom_range(0, 99);
		c.ch  = 2'($urandom);
		c.one = rand_angle();
		for (int i = 0; i < MAX_CH; i++)
			c.ang[i] = rand_angle();
		if (pick < 20)
			c.op = OP_SET_ALL;
		else if (pick < 45)
			c.op = OP_SET_ONE;
		else if (pick < 92)
			c.op = OP_TICK;
		else
			c.op = OP_RSVD;
		return c;
	endfunction

	function automatic servo_cmd_t tick_cmd();
		servo_cmd_t c;
		c    = servo_cmd_t'($urandom);
		c.op = OP_TICK;
		return c;
	endfunction

	task automatic send_item(input servo_cmd_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid        <= 1'b1;
		cmd.operation    <= c.op;
		cmd.channel      <= c.ch;
		cmd.single_angle <= c.one;
		cmd.angle_0      <= c.ang[0];
		cmd.angle_1      <= c.ang[1];
		cmd.angle_2      <= c.ang[2];
		cmd.angle_3      <= c.ang[3];
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input angle_t val);
		cfg.valid <= 1'b1;
		cfg.idx   <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
	endtask

	task automatic set_limits(input angle_t l0, input angle_t h0, input angle_t l1,
			input angle_t h1, input angle_t l2, input angle_t h2, input angle_t l3,
			input angle_t h3);
		write_reg(REG_MIN_CH0, l0);
		write_reg(REG_MAX_CH0, h0);
		write_reg(REG_MIN_CH1, l1);
		write_reg(REG_MAX_CH1, h1);
		write_reg(REG_MIN_CH2, l2);
		write_reg(REG_MAX_CH2, h2);
		write_reg(REG_MIN_CH3, l3);
		write_reg(REG_MAX_CH3, h3);
		// Writes past the last limit register must leave every limit alone.
		write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7)), angle_t'($urandom));
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int n_items);
		int sent;
		int burst;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				burst = $urandom_range(5, 40);
				repeat (burst) send_item(tick_cmd());
				sent += burst;
			end else begin
				send_item(rand_cmd());
				sent++;
			end
		end
	endtask

	initial begin : result_sink
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				res.ready <= 1'b0;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
			end
			res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd.valid && cmd.ready) || (res.valid && res.ready)
					|| (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n           <= 1'b0;
		cmd.valid        <= 1'b0;
		cmd.operation    <= OP_SET_ALL;
		cmd.channel      <= '0;
		cmd.single_angle <= '0;
		cmd.angle_0      <= '0;
		cmd.angle_1      <= '0;
		cmd.angle_2      <= '0;
		cmd.angle_3      <= '0;
		cfg.valid        <= 1'b0;
		cfg.idx          <= '0;
		cfg.data         <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items against the reset limits.
		send_idle_pct = 10;
		recv_idle_pct = 75;
		send_item(make_cmd(OP_TICK, 2'd0, 0, 0, 0, 0, 0));
		send_item(make_cmd(OP_RSVD, 2'd3, -128, 127, -128, 127, -1));
		send_item(make_cmd(OP_SET_ALL, 2'd2, 85, -128, 127, -128, 127));
		send_item(make_cmd(OP_SET_ONE, 2'd0, 127, 0, 0, 0, 0));
		send_item(make_cmd(OP_SET_ONE, 2'd1, -128, -1, -1, -1, -1));
		send_item(make_cmd(OP_SET_ONE, 2'd2, 127, 0, 0, 0, 0));
		send_item(make_cmd(OP_SET_ONE, 2'd3, -128, 0, 0, 0, 0));
		repeat (5) send_item(make_cmd(OP_TICK, 2'd1, -1, 0, 0, 0, 0));
		send_item(make_cmd(OP_RSVD, 2'd0, 0, 0, 0, 0, 0));
		send_item(make_cmd(OP_SET_ALL, 2'd0, 0, 0, 0, 0, 0));
		repeat (6) send_item(make_cmd(OP_TICK, 2'd0, 0, 0, 0, 0, 0));
		drain();

		// Full span on every channel.
		set_limits(-90, 90, -90, 90, -90, 90, -90, 90);
		random_phase(60);
		drain();

		// Minimum above maximum, and a channel pinned to a single angle.
		send_idle_pct = 75;
		recv_idle_pct = 10;
		set_limits(50, -50, 10, 20, -5, -5, 90, -90);
		random_phase(60);
		drain();

		// Limits at the ends of the register range drive the outputs into saturation.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limits(-128, 127, -128, 127, -90, 90, 127, -128);
		send_item(make_cmd(OP_SET_ALL, 2'd0, 0, 127, -128, 127, -128));
		hold_off_len = HOLD_CYCLES;
		repeat (140) send_item(tick_cmd());
		random_phase(40);
		drain();

		// Random limits, with a pause of the sender in the middle.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limits(angle_t'($urandom), angle_t'($urandom), angle_t'($urandom),
			angle_t'($urandom), angle_t'($urandom), angle_t'($urandom),
			angle_t'($urandom), angle_t'($urandom));
		random_phase(30);
		drain();
		random_phase(30);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limits(-90, 90, -90, 0, 0, 90, -20, 40);
		random_phase(30);
		drain();

		if (fail_total == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
